/* design/sh3r_pkg.sv */
// Shared types, constants and fixed-point helpers for the order-3 SH rotator.
`timescale 1ns / 1ps

package sh3r_pkg;

  // Field widths and fixed-point formats.
  localparam int COEFF_WIDTH   = 32;
  localparam int MATRIX_WIDTH  = 16;
  localparam int MATRIX_FRAC   = MATRIX_WIDTH - 2;
  localparam int CONST_FRAC    = 24;
  localparam int CONST_WIDTH   = 26;
  localparam int CFG_WIDTH     = 3 * MATRIX_WIDTH;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int NUM_COLS      = 5;

  // Internal datapath widths, sized from the worst-case magnitudes.
  localparam int S_WIDTH   = COEFF_WIDTH + 3;
  localparam int P_WIDTH   = MATRIX_WIDTH + 1;
  localparam int KK_WIDTH  = MATRIX_WIDTH + 4;
  localparam int SX_WIDTH  = S_WIDTH + 3;
  localparam int T_WIDTH   = COEFF_WIDTH + 10;
  localparam int D_WIDTH   = T_WIDTH + 3;
  localparam int RND_WIDTH = 96;

  typedef logic signed [COEFF_WIDTH-1:0] coef_t;
  typedef logic signed [MATRIX_WIDTH-1:0] mat_t;
  typedef logic signed [P_WIDTH-1:0]     p_t;
  typedef logic signed [KK_WIDTH-1:0]    kk_t;
  typedef logic signed [S_WIDTH-1:0]     s_t;
  typedef logic signed [SX_WIDTH-1:0]    sx_t;
  typedef logic signed [T_WIDTH-1:0]     t_t;
  typedef logic signed [D_WIDTH-1:0]     d_t;
  typedef logic signed [RND_WIDTH-1:0]   wide_t;
  typedef logic signed [CONST_WIDTH-1:0] const_t;
  typedef logic [CFG_WIDTH-1:0]          cfg_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROW0,
    REG_ROW1,
    REG_ROW2
  } reg_idx_t;

  // Scale constants with 24 fraction bits: sqrt(3) and sqrt(3)/2.
  // The factor 1/2 on the last result is a rounded shift by one.
  localparam const_t K_SQRT3      = const_t'(29058991);
  localparam const_t K_SQRT3_HALF = const_t'(14529495);

  // -1/3 and -2/3 in matrix format, rounded to nearest.
  localparam kk_t K1 = kk_t'(-(((1 << MATRIX_FRAC) + 1) / 3));
  localparam kk_t K2 = kk_t'(-(((1 << (MATRIX_FRAC + 1)) + 1) / 3));

  // Identity matrix rows after reset.
  localparam cfg_t ROW0_RESET = cfg_t'(1) << MATRIX_FRAC;
  localparam cfg_t ROW1_RESET = cfg_t'(1) << (MATRIX_FRAC + MATRIX_WIDTH);
  localparam cfg_t ROW2_RESET = cfg_t'(1) << (MATRIX_FRAC + 2 * MATRIX_WIDTH);

  // Coefficient range limits.
  localparam wide_t COEF_MAX = (wide_t'(1) <<< (COEFF_WIDTH - 1)) - wide_t'(1);
  localparam wide_t COEF_MIN = -COEF_MAX - wide_t'(1);

  // One input item.
  typedef struct packed {
    coef_t sh_in_8;
    coef_t sh_in_7;
    coef_t sh_in_6;
    coef_t sh_in_5;
    coef_t sh_in_4;
    coef_t sh_in_3;
    coef_t sh_in_2;
    coef_t sh_in_1;
    coef_t sh_in_0;
  } in_t;

  // One result item.
  typedef struct packed {
    coef_t sh_out_8;
    coef_t sh_out_7;
    coef_t sh_out_6;
    coef_t sh_out_5;
    coef_t sh_out_4;
    coef_t sh_out_3;
    coef_t sh_out_2;
    coef_t sh_out_1;
    coef_t sh_out_0;
  } out_t;

  // Contributions of one band-2 column lane to the five band-2 sums.
  typedef struct packed {
    t_t term_4;
    t_t term_3;
    t_t term_2;
    t_t term_1;
    t_t term_0;
  } lane_t;

  // Finished band-0 and band-1 results waiting for band 2.
  typedef struct packed {
    coef_t out_3;
    coef_t out_2;
    coef_t out_1;
    coef_t out_0;
  } early_t;

  // Arithmetic right shift by sh, rounding half away from zero.
  function automatic wide_t round_shr(wide_t p, int sh);
    wide_t half;
    half = wide_t'(1) <<< (sh - 1);
    if (p[RND_WIDTH-1]) begin
      half = half - wide_t'(1);
    end
    return (p + half) >>> sh;
  endfunction

  // Clamp to the signed coefficient range.
  function automatic coef_t sat_coef(wide_t v);
    coef_t r;
    if (v > COEF_MAX) begin
      r = coef_t'(COEF_MAX);
    end else if (v < COEF_MIN) begin
      r = coef_t'(COEF_MIN);
    end else begin
      r = coef_t'(v);
    end
    return r;
  endfunction

endpackage

/* design/sh3r_band1_lane.sv */
// One row of the band-1 matrix-vector product, rounded and saturated.
`timescale 1ns / 1ps

module sh3r_band1_lane (
  input  logic            clk,
  input  logic            negate,
  input  sh3r_pkg::coef_t x_a,
  input  sh3r_pkg::coef_t x_b,
  input  sh3r_pkg::coef_t x_c,
  input  sh3r_pkg::mat_t  m_a,
  input  sh3r_pkg::mat_t  m_b,
  input  sh3r_pkg::mat_t  m_c,
  output sh3r_pkg::coef_t res
);
  import sh3r_pkg::*;

  localparam int PROD_WIDTH = COEFF_WIDTH + MATRIX_WIDTH;

  logic signed [PROD_WIDTH-1:0] pa_r, pb_r, pc_r;
  wide_t sum;
  coef_t res_r, res_nxt;

  // Rescale each product, combine as a - b + c, then flip the sign if asked.
  always_comb begin
    sum = round_shr(wide_t'(pa_r), MATRIX_FRAC)
        - round_shr(wide_t'(pb_r), MATRIX_FRAC)
        + round_shr(wide_t'(pc_r), MATRIX_FRAC);
    if (negate) begin
      sum = -sum;
    end
    res_nxt = sat_coef(sum);
  end

  // Products in the first stage, the rounded sum in the second.
  always_ff @(posedge clk) begin
    pa_r  <= x_a * m_a;
    pb_r  <= x_b * m_b;
    pc_r  <= x_c * m_c;
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

/* design/sh3r_column.sv */
// One band-2 column lane: rotates one pre-multiplied term by one matrix column.
`timescale 1ns / 1ps

module sh3r_column (
  input  logic            clk,
  input  sh3r_pkg::s_t    s,
  input  sh3r_pkg::p_t    px,
  input  sh3r_pkg::p_t    py,
  input  sh3r_pkg::p_t    pz,
  input  sh3r_pkg::kk_t   k_bias,
  output sh3r_pkg::lane_t res
);
  import sh3r_pkg::*;

  localparam int SQ_WIDTH = 2 * P_WIDTH;
  localparam int SP_WIDTH = S_WIDTH + P_WIDTH;
  localparam int SK_WIDTH = S_WIDTH + KK_WIDTH;
  localparam int XP_WIDTH = SX_WIDTH + P_WIDTH;

  logic signed [SQ_WIDTH-1:0] sq;
  kk_t kk_r, kk_nxt;
  logic signed [SP_WIDTH-1:0] prod_x_r, prod_y_r;
  logic signed [SK_WIDTH-1:0] prod_k_r;
  sx_t sx_r, sx_nxt;
  sx_t sy_r, sy_nxt;
  t_t  e2_r, e2_nxt, e2_d_r;
  logic signed [XP_WIDTH-1:0] q0_r, q1_r, q3_r, q4a_r, q4b_r;
  lane_t res_r, res_nxt;

  // The zonal weight pz*pz + k depends on the matrix only; this register runs freely.
  // The user must keep the matrix stable while items are in flight (not enforced).
  always_comb begin
    sq     = pz * pz;
    kk_nxt = kk_t'(round_shr(wide_t'(sq), MATRIX_FRAC) + wide_t'(k_bias));
  end

  // Rescale the first-level products.
  always_comb begin
    sx_nxt = sx_t'(round_shr(wide_t'(prod_x_r), MATRIX_FRAC));
    sy_nxt = sx_t'(round_shr(wide_t'(prod_y_r), MATRIX_FRAC));
    e2_nxt = t_t'(round_shr(wide_t'(prod_k_r), MATRIX_FRAC));
  end

  // Rescale the second-level products into the five lane terms.
  always_comb begin
    res_nxt.term_0 = t_t'(round_shr(wide_t'(q0_r), MATRIX_FRAC));
    res_nxt.term_1 = t_t'(round_shr(wide_t'(q1_r), MATRIX_FRAC));
    res_nxt.term_2 = e2_d_r;
    res_nxt.term_3 = t_t'(round_shr(wide_t'(q3_r), MATRIX_FRAC));
    res_nxt.term_4 = t_t'(round_shr(wide_t'(q4a_r), MATRIX_FRAC)
                        - round_shr(wide_t'(q4b_r), MATRIX_FRAC));
  end

  // Four stages: first products, rescale, second products, rescale.
  always_ff @(posedge clk) begin
    kk_r     <= kk_nxt;
    prod_x_r <= s * px;
    prod_y_r <= s * py;
    prod_k_r <= s * kk_r;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    e2_r     <= e2_nxt;
    q0_r     <= sx_r * py;
    q1_r     <= sy_r * pz;
    q3_r     <= sx_r * pz;
    q4a_r    <= sx_r * px;
    q4b_r    <= sy_r * py;
    e2_d_r   <= e2_r;
    res_r    <= res_nxt;
  end

  assign res = res_r;

endmodule

/* design/sh3r_merge.sv */
// Merges the column lanes into band-2 results and registers the full result item.
`timescale 1ns / 1ps

module sh3r_merge (
  input  logic                                    clk,
  input  sh3r_pkg::lane_t [sh3r_pkg::NUM_COLS-1:0] lanes,
  input  sh3r_pkg::early_t                        early,
  output sh3r_pkg::out_t                          res
);
  import sh3r_pkg::*;

  localparam int P6_WIDTH = D_WIDTH + CONST_WIDTH;

  d_t d0_nxt, d1_nxt, d2_nxt, d3_nxt, d4_nxt;
  d_t d0_r, d1_r, d2_r, d3_r, d4_r;
  logic signed [P6_WIDTH-1:0] prod6_r;
  d_t d0_d_r, n1_r, n3_r, r8_r, r8_nxt;
  out_t res_r, res_nxt;

  // Sum the lane contributions term by term.
  always_comb begin
    d0_nxt = '0;
    d1_nxt = '0;
    d2_nxt = '0;
    d3_nxt = '0;
    d4_nxt = '0;
    for (int j = 0; j < NUM_COLS; j++) begin
      d0_nxt = d0_nxt + d_t'(lanes[j].term_0);
      d1_nxt = d1_nxt + d_t'(lanes[j].term_1);
      d2_nxt = d2_nxt + d_t'(lanes[j].term_2);
      d3_nxt = d3_nxt + d_t'(lanes[j].term_3);
      d4_nxt = d4_nxt + d_t'(lanes[j].term_4);
    end
  end

  // Halving of the last sum, rounded away from zero.
  assign r8_nxt = d_t'(round_shr(wide_t'(d4_r), 1));

  // Final scaling and saturation of the band-2 results; bands 0 and 1 pass through.
  always_comb begin
    res_nxt.sh_out_0 = early.out_0;
    res_nxt.sh_out_1 = early.out_1;
    res_nxt.sh_out_2 = early.out_2;
    res_nxt.sh_out_3 = early.out_3;
    res_nxt.sh_out_4 = sat_coef(wide_t'(d0_d_r));
    res_nxt.sh_out_5 = sat_coef(wide_t'(n1_r));
    res_nxt.sh_out_6 = sat_coef(round_shr(wide_t'(prod6_r), CONST_FRAC));
    res_nxt.sh_out_7 = sat_coef(wide_t'(n3_r));
    res_nxt.sh_out_8 = sat_coef(wide_t'(r8_r));
  end

  // Sum stage, scale stage, output stage.
  always_ff @(posedge clk) begin
    d0_r    <= d0_nxt;
    d1_r    <= d1_nxt;
    d2_r    <= d2_nxt;
    d3_r    <= d3_nxt;
    d4_r    <= d4_nxt;
    prod6_r <= d2_r * K_SQRT3_HALF;
    d0_d_r  <= d0_r;
    n1_r    <= -d1_r;
    n3_r    <= -d3_r;
    r8_r    <= r8_nxt;
    res_r   <= res_nxt;
  end

  assign res = res_r;

endmodule

/* design/sh_order3_rotate.sv */
// Top level of the order-3 spherical harmonic rotator.
//
//   Channel   Ports                            Handshake
//   input     start, busy, in_data             taken when start and not busy
//   result    out_valid, out_data              one-cycle strobe, never held off
//   config    cfg_we, cfg_index, cfg_data      written when cfg_we is high
//
// One item is taken every clock cycle in which start is high and busy is low; each
// result is set by the input and pre-multiply registers, the band-2 column lanes (two levels of
// multiply and rescale) and then the merge, scale and saturate stages.
// Synchronous reset empties the pipeline, loads the identity matrix and holds
// busy high; busy drops at the first clock edge that sees rst_n high and then
// stays low.
// The receiver cannot stall, so nothing backs up and nothing is dropped.
`timescale 1ns / 1ps

module sh_order3_rotate (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  sh3r_pkg::in_t                         in_data,
  output logic                                  out_valid,
  output sh3r_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [sh3r_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  sh3r_pkg::cfg_t                        cfg_data
);
  import sh3r_pkg::*;

  localparam int LATENCY   = 10;
  localparam int DLY_DEPTH = 6;
  localparam int P6_WIDTH  = COEFF_WIDTH + CONST_WIDTH;
  localparam kk_t COL_K [NUM_COLS] = '{K1, K1, K2, K2, K2};

  logic                accept;
  logic                busy_r;
  logic [LATENCY-1:0]  valid_r;
  cfg_t                mrow_r [3];
  mat_t                m [3][3];
  p_t                  col_p [NUM_COLS][3];

  in_t                 x_r;
  coef_t               x0_d1_r, x0_d2_r;
  coef_t               x4_d_r, x5_d_r, x7_d_r, x8_d_r;
  logic signed [P6_WIDTH-1:0] prod6_r;
  s_t                  s_nxt [NUM_COLS];
  s_t                  s_r [NUM_COLS];
  coef_t               b1_out1, b1_out2, b1_out3;
  early_t              early_now;
  early_t              dly_r [DLY_DEPTH];
  lane_t [NUM_COLS-1:0] lane_res;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = valid_r[LATENCY-1];

  // Control: busy flag, item valid pipeline and the matrix registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      valid_r   <= '0;
      mrow_r[0] <= ROW0_RESET;
      mrow_r[1] <= ROW1_RESET;
      mrow_r[2] <= ROW2_RESET;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= {valid_r[LATENCY-2:0], accept};
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW0: mrow_r[0] <= cfg_data;
          REG_ROW1: mrow_r[1] <= cfg_data;
          REG_ROW2: mrow_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Unpack the matrix entries.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = mat_t'(mrow_r[i][j*MATRIX_WIDTH +: MATRIX_WIDTH]);
      end
    end
  end

  // Column vectors for the five band-2 lanes: single columns and column sums.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      col_p[0][r] = p_t'(m[r][0]);
      col_p[1][r] = p_t'(m[r][2]);
      col_p[2][r] = p_t'(m[r][0]) + p_t'(m[r][1]);
      col_p[3][r] = p_t'(m[r][0]) + p_t'(m[r][2]);
      col_p[4][r] = p_t'(m[r][1]) + p_t'(m[r][2]);
    end
  end

  // Sparse pre-multiply of band 2 into the lane inputs.
  always_comb begin
    s_nxt[0] = s_t'(x7_d_r) + s_t'(x8_d_r) + s_t'(x8_d_r) - s_t'(x5_d_r);
    s_nxt[1] = s_t'(x4_d_r) + s_t'(round_shr(wide_t'(prod6_r), CONST_FRAC))
             + s_t'(x7_d_r) + s_t'(x8_d_r);
    s_nxt[2] = s_t'(x4_d_r);
    s_nxt[3] = -s_t'(x7_d_r);
    s_nxt[4] = -s_t'(x5_d_r);
  end

  // Band 0 and band 1 are done early and wait for band 2.
  always_comb begin
    early_now.out_0 = x0_d2_r;
    early_now.out_1 = b1_out1;
    early_now.out_2 = b1_out2;
    early_now.out_3 = b1_out3;
  end

  // Input register, pre-multiply stages and the alignment delay line.
  always_ff @(posedge clk) begin
    x_r     <= in_data;
    x0_d1_r <= x_r.sh_in_0;
    x0_d2_r <= x0_d1_r;
    x4_d_r  <= x_r.sh_in_4;
    x5_d_r  <= x_r.sh_in_5;
    x7_d_r  <= x_r.sh_in_7;
    x8_d_r  <= x_r.sh_in_8;
    prod6_r <= x_r.sh_in_6 * K_SQRT3;
    for (int c = 0; c < NUM_COLS; c++) begin
      s_r[c] <= s_nxt[c];
    end
    dly_r[0] <= early_now;
    for (int i = 1; i < DLY_DEPTH; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  // Band-1 rows: result 1 from matrix row 1, result 2 from row 2 with the
  // sign flipped, result 3 from row 0.
  sh3r_band1_lane u_b1_row1 (
    .clk    (clk),
    .negate (1'b0),
    .x_a    (x_r.sh_in_1),
    .x_b    (x_r.sh_in_2),
    .x_c    (x_r.sh_in_3),
    .m_a    (m[1][1]),
    .m_b    (m[1][2]),
    .m_c    (m[1][0]),
    .res    (b1_out1)
  );

  sh3r_band1_lane u_b1_row2 (
    .clk    (clk),
    .negate (1'b1),
    .x_a    (x_r.sh_in_1),
    .x_b    (x_r.sh_in_2),
    .x_c    (x_r.sh_in_3),
    .m_a    (m[2][1]),
    .m_b    (m[2][2]),
    .m_c    (m[2][0]),
    .res    (b1_out2)
  );

  sh3r_band1_lane u_b1_row0 (
    .clk    (clk),
    .negate (1'b0),
    .x_a    (x_r.sh_in_1),
    .x_b    (x_r.sh_in_2),
    .x_c    (x_r.sh_in_3),
    .m_a    (m[0][1]),
    .m_b    (m[0][2]),
    .m_c    (m[0][0]),
    .res    (b1_out3)
  );

  // Band-2 column lanes working side by side.
  for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
    sh3r_column u_col (
      .clk    (clk),
      .s      (s_r[c]),
      .px     (col_p[c][0]),
      .py     (col_p[c][1]),
      .pz     (col_p[c][2]),
      .k_bias (COL_K[c]),
      .res    (lane_res[c])
    );
  end

  // Merge of the lanes and the final result register.
  sh3r_merge u_merge (
    .clk   (clk),
    .lanes (lane_res),
    .early (dly_r[DLY_DEPTH-1]),
    .res   (out_data)
  );

  // Every item taken comes out exactly once.
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("item taken without a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without an item");

  // Band 0 passes through unchanged along the delay line.
  a_band0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sh_out_0 == $past(in_data.sh_in_0, LATENCY)))
    else $error("band 0 result does not match its item");

endmodule

/* tb/sh_order3_rotate_test.sv */
// Self-checking testbench for the order-3 spherical harmonic rotator.
`timescale 1ns / 1ps

module sh_order3_rotate_test;
  import sh3r_pkg::*;

  // Coefficient extremes and handy fixed-point values.
  localparam coef_t COEF_HI = 32'sh7fff_ffff;
  localparam coef_t COEF_LO = 32'sh8000_0000;
  localparam coef_t ONE_Q16 = 32'sh0001_0000;
  localparam longint COEF_TOP = 64'sd2147483647;
  localparam longint COEF_BOT = -64'sd2147483648;
  localparam longint INT64_TOP = 64'sh7fff_ffff_ffff_ffff;

  // Scale constants with 24 fraction bits, and -1/3, -2/3 in matrix format.
  localparam int Q24 = 24;
  localparam longint SQRT3_Q24 = 29058991;
  localparam longint SQRT3_HALF_Q24 = 14529495;
  localparam longint HALF_Q24 = 8388608;
  localparam longint THIRD_NEG = -(((longint'(1) << MATRIX_FRAC) + 1) / 3);
  localparam longint TWO_THIRDS_NEG = -(((longint'(1) << (MATRIX_FRAC + 1)) + 1) / 3);

  // Index past the last register; writes there must be ignored.
  localparam logic [CFG_IDX_WIDTH-1:0] IDX_UNUSED = 2'd3;

  typedef logic signed [127:0] prod_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One step of the directed plan: an item or a register write.
  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_WIDTH-1:0] idx;
    cfg_t val;
    in_t data;
    bit typed;
    out_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  cfg_t cfg_data = '0;

  // Matrix rows as the block should hold them.
  cfg_t row_model [3];
  out_t pending_rotations [$];
  plan_row_t plan [$];
  int mismatch_count = 0;
  bit steady = 1'b0;

  sh_order3_rotate dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("sh_order3_rotate verification failed");
    $finish;
  end

  // Round a*b / 2^sh half away from zero.
  function automatic longint scale_round(longint a, longint b, int sh);
    prod_t p;
    prod_t mag;
    prod_t r;
    p = prod_t'(a) * prod_t'(b);
    mag = (p < 0) ? -p : p;
    r = (mag + (prod_t'(1) <<< (sh - 1))) >>> sh;
    if (r > prod_t'(INT64_TOP)) begin
      r = prod_t'(INT64_TOP);
    end
    return (p < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic longint mat_mul(longint a, longint b);
    return scale_round(a, b, MATRIX_FRAC);
  endfunction

  function automatic coef_t clamp_coef(longint v);
    if (v > COEF_TOP) begin
      v = COEF_TOP;
    end
    if (v < COEF_BOT) begin
      v = COEF_BOT;
    end
    return coef_t'(v);
  endfunction

  // Add one dense band-2 column, the source s rotated by (px, py, pz).
  function automatic void add_column(inout longint d0, d1, d2, d3, d4,
                                     input longint s, px, py, pz, k);
    longint sx;
    longint sy;
    sx = mat_mul(s, px);
    sy = mat_mul(s, py);
    d0 += mat_mul(sx, py);
    d1 += mat_mul(sy, pz);
    d2 += mat_mul(s, mat_mul(pz, pz) + k);
    d3 += mat_mul(sx, pz);
    d4 += mat_mul(sx, px) - mat_mul(sy, py);
  endfunction

  // Expected rotation of one coefficient set under the current matrix.
  function automatic out_t rotate_coeffs(in_t it);
    longint m [3][3];
    longint x [9];
    longint d0;
    longint d1;
    longint d2;
    longint d3;
    longint d4;
    longint s0;
    longint s1;
    out_t r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = longint'(mat_t'(row_model[i][j*MATRIX_WIDTH +: MATRIX_WIDTH]));
      end
    end
    for (int i = 0; i < 9; i++) begin
      x[i] = longint'(coef_t'(it[i*COEFF_WIDTH +: COEFF_WIDTH]));
    end
    r.sh_out_0 = clamp_coef(x[0]);

    // Band 1 is a signed, permuted matrix-vector product.
    r.sh_out_1 = clamp_coef(mat_mul(x[1], m[1][1]) - mat_mul(x[2], m[1][2])
                            + mat_mul(x[3], m[1][0]));
    r.sh_out_2 = clamp_coef(-mat_mul(x[1], m[2][1]) + mat_mul(x[2], m[2][2])
                            - mat_mul(x[3], m[2][0]));
    r.sh_out_3 = clamp_coef(mat_mul(x[1], m[0][1]) - mat_mul(x[2], m[0][2])
                            + mat_mul(x[3], m[0][0]));

    // Band 2: sparse pre-multiply, then five dense columns.
    d0 = 0;
    d1 = 0;
    d2 = 0;
    d3 = 0;
    d4 = 0;
    s0 = x[7] + x[8] + x[8] - x[5];
    s1 = x[4] + scale_round(x[6], SQRT3_Q24, Q24) + x[7] + x[8];
    add_column(d0, d1, d2, d3, d4, s0, m[0][0], m[1][0], m[2][0], THIRD_NEG);
    add_column(d0, d1, d2, d3, d4, s1, m[0][2], m[1][2], m[2][2], THIRD_NEG);
    add_column(d0, d1, d2, d3, d4, x[4], m[0][0] + m[0][1], m[1][0] + m[1][1],
               m[2][0] + m[2][1], TWO_THIRDS_NEG);
    add_column(d0, d1, d2, d3, d4, -x[7], m[0][0] + m[0][2], m[1][0] + m[1][2],
               m[2][0] + m[2][2], TWO_THIRDS_NEG);
    add_column(d0, d1, d2, d3, d4, -x[5], m[0][1] + m[0][2], m[1][1] + m[1][2],
               m[2][1] + m[2][2], TWO_THIRDS_NEG);
    r.sh_out_4 = clamp_coef(d0);
    r.sh_out_5 = clamp_coef(-d1);
    r.sh_out_6 = clamp_coef(scale_round(d2, SQRT3_HALF_Q24, Q24));
    r.sh_out_7 = clamp_coef(-d3);
    r.sh_out_8 = clamp_coef(scale_round(d4, HALF_Q24, Q24));
    return r;
  endfunction

  function automatic logic [9*COEFF_WIDTH-1:0] cat9(input coef_t c0, c1, c2, c3, c4,
                                                    c5, c6, c7, c8);
    return {c8, c7, c6, c5, c4, c3, c2, c1, c0};
  endfunction

  // Mix of extremes, small values and full-range random coefficients.
  function automatic coef_t rand_coef();
    coef_t v;
    case ($urandom_range(0, 7))
      0: v = COEF_HI;
      1: v = COEF_LO;
      2: v = coef_t'(int'($urandom_range(0, 2097152)) - 1048576);
      3: v = coef_t'(int'($urandom_range(0, 8)) - 4);
      default: v = coef_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic in_t random_coeffs();
    return cat9(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                rand_coef(), rand_coef(), rand_coef(), rand_coef());
  endfunction

  // Matrix entries: extremes, rotation-like values and full-range noise.
  function automatic mat_t rand_entry();
    mat_t v;
    case ($urandom_range(0, 5))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = '0;
      3: v = mat_t'(int'($urandom_range(0, 32768)) - 16384);
      default: v = mat_t'($urandom);
    endcase
    return v;
  endfunction

  // Append one row at the end of the directed plan.
  function automatic void append_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  // Queue the result expected for an item just taken.
  function automatic void queue_expected(out_t w);
    pending_rotations.insert(pending_rotations.size(), w);
  endfunction

  function automatic void add_item(in_t d);
    append_row('{ROW_ITEM, '0, '0, d, 1'b0, '0});
  endfunction

  function automatic void add_known(in_t d, out_t w);
    append_row('{ROW_ITEM, '0, '0, d, 1'b1, w});
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_WIDTH-1:0] idx, cfg_t val);
    append_row('{ROW_CFG, idx, val, '0, 1'b0, '0});
  endfunction

  // Offer one item until taken, then idle at random unless in a steady stretch.
  task automatic send_item(in_t item, bit typed, out_t want);
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    queue_expected(typed ? want : rotate_coeffs(item));
    if (!steady) begin
      while ($urandom_range(0, 99) < 33) begin
        start <= 1'b0;
        in_data <= random_coeffs();
        @(posedge clk);
      end
    end
  endtask

  // Stop offering items and wait until every expected result has come.
  task automatic settle();
    start <= 1'b0;
    while (pending_rotations.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, cfg_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx < 3) begin
      row_model[idx] = val;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_rotations.size() == 0) begin
        $error("unexpected result item: %h", out_data);
        mismatch_count++;
      end else begin
        want = pending_rotations.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (out_data[i*COEFF_WIDTH +: COEFF_WIDTH] !== want[i*COEFF_WIDTH +: COEFF_WIDTH])
          begin
            $error("sh_out_%0d mismatch: expected %0d, got %0d", i,
                   $signed(want[i*COEFF_WIDTH +: COEFF_WIDTH]),
                   $signed(out_data[i*COEFF_WIDTH +: COEFF_WIDTH]));
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    row_model[0] = ROW0_RESET;
    row_model[1] = ROW1_RESET;
    row_model[2] = ROW2_RESET;

    // Directed part. With the identity matrix and band 2 at zero, bands 0
    // and 1 pass through exactly.
    add_known('0, '0);
    add_known(cat9(COEF_HI, COEF_HI, COEF_LO, 1, 0, 0, 0, 0, 0),
              cat9(COEF_HI, COEF_HI, COEF_LO, 1, 0, 0, 0, 0, 0));
    add_known(cat9(COEF_LO, COEF_LO, COEF_HI, -1, 0, 0, 0, 0, 0),
              cat9(COEF_LO, COEF_LO, COEF_HI, -1, 0, 0, 0, 0, 0));
    add_known(cat9(0, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 0, 0, 0, 0, 0),
              cat9(0, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 0, 0, 0, 0, 0));
    add_item(cat9(COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI,
                  COEF_HI, COEF_HI));
    add_item(cat9(COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO,
                  COEF_LO, COEF_LO));
    add_item({9{32'h5555_aaaa}});
    add_item(cat9(0, 0, 0, 0, ONE_Q16, 0, 0, 0, 0));
    add_item(cat9(0, 0, 0, 0, 0, ONE_Q16, 0, 0, 0));
    add_item(cat9(0, 0, 0, 0, 0, 0, ONE_Q16, 0, 0));
    add_item(cat9(0, 0, 0, 0, 0, 0, 0, ONE_Q16, 0));
    add_item(cat9(0, 0, 0, 0, 0, 0, 0, 0, ONE_Q16));
    add_item(cat9(-ONE_Q16, ONE_Q16, -ONE_Q16, ONE_Q16, -ONE_Q16, ONE_Q16, -ONE_Q16,
                  ONE_Q16, -ONE_Q16));

    // m11 = -2.0 drives band 1 into saturation on both sides.
    add_cfg(REG_ROW1, 48'h0000_8000_0000);
    add_known(cat9(0, COEF_LO, 0, 0, 0, 0, 0, 0, 0), cat9(0, COEF_HI, 0, 0, 0, 0, 0, 0, 0));
    add_known(cat9(0, COEF_HI, 0, 0, 0, 0, 0, 0, 0), cat9(0, COEF_LO, 0, 0, 0, 0, 0, 0, 0));

    // A write past the last register changes nothing.
    add_cfg(IDX_UNUSED, 48'hffff_ffff_ffff);
    add_known(cat9(0, COEF_LO, 0, 0, 0, 0, 0, 0, 0), cat9(0, COEF_HI, 0, 0, 0, 0, 0, 0, 0));

    // Matrices at both ends of the entry range.
    add_cfg(REG_ROW0, 48'h8000_8000_8000);
    add_cfg(REG_ROW1, 48'h8000_8000_8000);
    add_cfg(REG_ROW2, 48'h8000_8000_8000);
    add_item(cat9(COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI,
                  COEF_HI, COEF_HI));
    add_item(cat9(COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO,
                  COEF_LO, COEF_LO));
    add_item(cat9(COEF_HI, COEF_LO, COEF_HI, COEF_LO, COEF_HI, COEF_LO, COEF_HI,
                  COEF_LO, COEF_HI));
    add_cfg(REG_ROW0, 48'h7fff_7fff_7fff);
    add_cfg(REG_ROW1, 48'h7fff_7fff_7fff);
    add_cfg(REG_ROW2, 48'h7fff_7fff_7fff);
    add_item(cat9(COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI,
                  COEF_HI, COEF_HI));
    add_item(cat9(COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO,
                  COEF_LO, COEF_LO));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_CFG) begin
        settle();
        write_reg(plan[n].idx, plan[n].val);
      end else begin
        send_item(plan[n].data, plan[n].typed, plan[n].want);
      end
    end

    // Random phases, each under its own matrix; phase 4 never idles.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph == 0) begin
        write_reg(REG_ROW0, ROW0_RESET);
        write_reg(REG_ROW1, ROW1_RESET);
        write_reg(REG_ROW2, ROW2_RESET);
      end else begin
        write_reg(REG_ROW0, {rand_entry(), rand_entry(), rand_entry()});
        write_reg(REG_ROW1, {rand_entry(), rand_entry(), rand_entry()});
        if ($urandom_range(0, 3) == 0) begin
          write_reg(IDX_UNUSED, cfg_t'({$urandom, $urandom}));
        end
        write_reg(REG_ROW2, {rand_entry(), rand_entry(), rand_entry()});
      end
      steady = (ph == 4);
      repeat (240) begin
        send_item(random_coeffs(), 1'b0, '0);
      end
    end

    // Drain, then give stray results time to show up.
    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sh_order3_rotate verification clean");
    end else begin
      $display("sh_order3_rotate verification failed");
    end
    $finish;
  end

endmodule
